// ===== design/mspfr_pkg.sv =====
// Shared types and constants for the MSP v1 frame receiver.
// Used by the controller, the datapath and the top level; depends on nothing.

package mspfr_pkg;

	localparam int MSP_DEPTH_MAX = 64;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_GT     = 8'h3E;

	typedef struct packed {
		logic load_size;
		logic load_cmd;
		logic body_xor;
		logic store;
		logic start_run;
		logic fetch;
		logic advance;
	} dp_cmd_t;

	typedef struct packed {
		logic size_ok;
		logic body_done;
		logic xor_ok;
		logic size_zero;
		logic run_last;
	} dp_status_t;

endpackage

// ===== design/mspfr_datapath.sv =====
// Datapath of the MSP v1 frame receiver: size, command, checksum, payload buffer and run index.
// Depends on mspfr_pkg; driven by mspfr_ctrl through command and status structs.

module mspfr_datapath #(
	parameter int PAYLOAD_DEPTH = mspfr_pkg::MSP_DEPTH_MAX
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [7:0]             rx_byte,
	input  mspfr_pkg::dp_cmd_t     cmd,
	output mspfr_pkg::dp_status_t  status,
	output logic [7:0]             command,
	output logic [6:0]             payload_size,
	output logic [7:0]             data_byte,
	output logic [5:0]             byte_index,
	output logic                   empty_payload,
	output logic                   last
);
	import mspfr_pkg::*;

	localparam int ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

	logic [6:0] expected_size_q;
	logic [7:0] frame_command_q;
	logic [7:0] running_xor_q;
	logic [6:0] bytes_received_q;
	logic [5:0] run_idx_q;
	logic       empty_q;
	logic [7:0] rd_data_q;
	logic [7:0] store_q [PAYLOAD_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_size_q  <= '0;
			frame_command_q  <= '0;
			running_xor_q    <= '0;
			bytes_received_q <= '0;
			run_idx_q        <= '0;
			empty_q          <= 1'b0;
		end else begin
			if (cmd.load_size) begin
				expected_size_q <= rx_byte[6:0];
				running_xor_q   <= rx_byte;
			end
			if (cmd.load_cmd) begin
				frame_command_q  <= rx_byte;
				running_xor_q    <= running_xor_q ^ rx_byte;
				bytes_received_q <= '0;
			end
			if (cmd.body_xor) begin
				running_xor_q <= running_xor_q ^ rx_byte;
			end
			if (cmd.store) begin
				bytes_received_q <= bytes_received_q + 7'd1;
			end
			if (cmd.start_run) begin
				run_idx_q <= '0;
				empty_q   <= (expected_size_q == 7'd0);
			end
			if (cmd.advance) begin
				run_idx_q <= run_idx_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			store_q[bytes_received_q[ADDR_W-1:0]] <= rx_byte;
		end
		if (cmd.fetch) begin
			rd_data_q <= store_q[run_idx_q[ADDR_W-1:0]];
		end
	end

	always_comb begin
		status.size_ok   = ({1'b0, rx_byte} <= 9'(PAYLOAD_DEPTH));
		status.body_done = (bytes_received_q >= expected_size_q);
		status.xor_ok    = ((running_xor_q ^ rx_byte) == 8'd0);
		status.size_zero = (expected_size_q == 7'd0);
		status.run_last  = empty_q || (({1'b0, run_idx_q} + 7'd1) == expected_size_q);
	end

	assign command       = frame_command_q;
	assign payload_size  = expected_size_q;
	assign data_byte     = empty_q ? 8'd0 : rd_data_q;
	assign byte_index    = run_idx_q;
	assign empty_payload = empty_q;
	assign last          = status.run_last;

endmodule

// ===== design/mspfr_ctrl.sv =====
// Controller of the MSP v1 frame receiver: header parsing and result run sequencing.
// Depends on mspfr_pkg; commands mspfr_datapath and owns both handshakes.

module mspfr_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   rx_valid,
	output logic                   rx_stall,
	input  logic [7:0]             rx_byte,
	output logic                   res_valid,
	input  logic                   res_stall,
	input  mspfr_pkg::dp_status_t  status,
	output mspfr_pkg::dp_cmd_t     cmd
);
	import mspfr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DOLLAR,
		ST_M,
		ST_ARROW,
		ST_SIZE,
		ST_BODY,
		ST_FETCH,
		ST_SHOW
	} state_t;

	state_t state_q;
	logic   rx_stall_q;
	logic   res_valid_q;
	logic   rx_take;
	logic   res_take;

	assign rx_take   = rx_valid && !rx_stall_q;
	assign res_take  = res_valid_q && !res_stall;
	assign rx_stall  = rx_stall_q;
	assign res_valid = res_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_ARROW: cmd.load_size = rx_take && status.size_ok;
			ST_SIZE:  cmd.load_cmd  = rx_take;
			ST_BODY: begin
				cmd.body_xor  = rx_take;
				cmd.store     = rx_take && !status.body_done;
				cmd.start_run = rx_take && status.body_done && status.xor_ok;
			end
			ST_FETCH: cmd.fetch   = 1'b1;
			ST_SHOW:  cmd.advance = res_take && !status.run_last;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rx_stall_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (rx_take) begin
					state_q <= (rx_byte == CH_DOLLAR) ? ST_DOLLAR : ST_IDLE;
				end
				ST_DOLLAR: if (rx_take) begin
					state_q <= (rx_byte == CH_M) ? ST_M : ST_IDLE;
				end
				ST_M: if (rx_take) begin
					state_q <= (rx_byte == CH_GT) ? ST_ARROW : ST_IDLE;
				end
				ST_ARROW: if (rx_take) begin
					state_q <= status.size_ok ? ST_SIZE : ST_IDLE;
				end
				ST_SIZE: if (rx_take) begin
					state_q <= ST_BODY;
				end
				ST_BODY: if (rx_take && status.body_done) begin
					if (!status.xor_ok) begin
						state_q <= ST_IDLE;
					end else if (status.size_zero) begin
						state_q     <= ST_SHOW;
						rx_stall_q  <= 1'b1;
						res_valid_q <= 1'b1;
					end else begin
						state_q    <= ST_FETCH;
						rx_stall_q <= 1'b1;
					end
				end
				ST_FETCH: begin
					state_q     <= ST_SHOW;
					res_valid_q <= 1'b1;
				end
				ST_SHOW: if (res_take) begin
					res_valid_q <= 1'b0;
					if (status.run_last) begin
						state_q    <= ST_IDLE;
						rx_stall_q <= 1'b0;
					end else begin
						state_q <= ST_FETCH;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== design/msp_frame_receiver_unit.sv =====
// Top level of the MSP v1 frame receiver: controller plus datapath.
// Depends on mspfr_pkg, mspfr_ctrl and mspfr_datapath.
//
//   channel   handshake             payload
//   rx        rx_valid / rx_stall   rx_byte
//   result    res_valid / res_stall command, payload_size, data_byte, byte_index,
//                                   empty_payload, last
//
// The rx side takes a byte when rx_valid is high and rx_stall low. A good frame stalls
// the rx side while its run is sent: each payload beat is read from the buffer and
// then presented; an empty frame presents one beat with no buffer read. The buffer is
// a memory of PAYLOAD_DEPTH bytes. Reset clears the parser state and takes effect at
// once; the buffer is not cleared. A stalled result beat holds its fields until taken.

module msp_frame_receiver_unit #(
	parameter int PAYLOAD_DEPTH = mspfr_pkg::MSP_DEPTH_MAX
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] command,
	output logic [6:0] payload_size,
	output logic [7:0] data_byte,
	output logic [5:0] byte_index,
	output logic       empty_payload,
	output logic       last
);
	import mspfr_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	mspfr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_stall  (rx_stall),
		.rx_byte   (rx_byte),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.status    (status),
		.cmd       (cmd)
	);

	mspfr_datapath #(
		.PAYLOAD_DEPTH (PAYLOAD_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx_byte       (rx_byte),
		.cmd           (cmd),
		.status        (status),
		.command       (command),
		.payload_size  (payload_size),
		.data_byte     (data_byte),
		.byte_index    (byte_index),
		.empty_payload (empty_payload),
		.last          (last)
	);

endmodule

// ===== tb/sv/tb_msp_frame_receiver_unit.sv =====
// Self-checking testbench for msp_frame_receiver_unit: directed frames, then random traffic.
// Depends on mspfr_pkg and the msp_frame_receiver_unit RTL; needs no other files.

module tb_msp_frame_receiver_unit;

	import mspfr_pkg::*;

	localparam int DEPTH        = MSP_DEPTH_MAX;
	localparam int RANDOM_ITEMS = 280;
	localparam int IDLE_LIMIT   = 5000;
	localparam int SHOWN_ERRORS = 10;
	localparam int TRAIL_CYCLES = 20;

	typedef enum logic [2:0] {
		PH_IDLE, PH_DOLLAR, PH_M, PH_ARROW, PH_SIZE, PH_BODY
	} parse_phase_t;

	typedef enum int {
		FK_GOOD, FK_BAD_SUM, FK_BROKEN, FK_OVERSIZE, FK_TRUNCATED, FK_NOISE
	} frame_kind_t;

	typedef enum int {
		RS_OPEN, RS_RANDOM, RS_HEAVY, RS_SQUARE
	} res_stall_mode_t;

	typedef struct {
		logic [7:0] cmd;
		logic [6:0] size;
		logic [7:0] data;
		logic [5:0] idx;
		logic       empty;
		logic       last;
	} frame_beat_t;

	typedef struct packed {
		logic [7:0] b;
		logic       typed;
		logic       has_res;
		logic [7:0] cmd;
	} dir_row_t;

	localparam logic [7:0] HDR [3] = '{CH_DOLLAR, CH_M, CH_GT};

	// Rows flagged as typed carry their own expectation; the others go through the predictor.
	localparam dir_row_t DIR_ROWS [26] = '{
		'{CH_DOLLAR, 1'b0, 1'b0, 8'h00}, '{CH_M, 1'b0, 1'b0, 8'h00},
		'{CH_GT, 1'b0, 1'b0, 8'h00}, '{8'h00, 1'b0, 1'b0, 8'h00},
		'{8'hFF, 1'b0, 1'b0, 8'h00}, '{8'hFF, 1'b1, 1'b1, 8'hFF},
		'{CH_DOLLAR, 1'b0, 1'b0, 8'h00}, '{CH_DOLLAR, 1'b1, 1'b0, 8'h00},
		'{CH_M, 1'b1, 1'b0, 8'h00},
		'{CH_DOLLAR, 1'b0, 1'b0, 8'h00}, '{CH_M, 1'b0, 1'b0, 8'h00},
		'{CH_GT, 1'b0, 1'b0, 8'h00}, '{8'h41, 1'b1, 1'b0, 8'h00},
		'{CH_DOLLAR, 1'b0, 1'b0, 8'h00}, '{CH_M, 1'b0, 1'b0, 8'h00},
		'{CH_GT, 1'b0, 1'b0, 8'h00}, '{8'h00, 1'b0, 1'b0, 8'h00},
		'{8'h07, 1'b0, 1'b0, 8'h00}, '{8'h00, 1'b1, 1'b0, 8'h00},
		'{CH_DOLLAR, 1'b0, 1'b0, 8'h00}, '{CH_M, 1'b0, 1'b0, 8'h00},
		'{CH_GT, 1'b0, 1'b0, 8'h00}, '{8'h01, 1'b0, 1'b0, 8'h00},
		'{8'h00, 1'b0, 1'b0, 8'h00}, '{8'hFF, 1'b0, 1'b0, 8'h00},
		'{8'hFE, 1'b0, 1'b0, 8'h00}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       rx_valid = 1'b0;
	logic       rx_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic [7:0] command;
	logic [6:0] payload_size;
	logic [7:0] data_byte;
	logic [5:0] byte_index;
	logic       empty_payload;
	logic       last;

	logic       row_typed = 1'b0;
	logic       row_has_res = 1'b0;
	logic [7:0] row_cmd = 8'h00;

	parse_phase_t phase = PH_IDLE;
	logic [6:0]   want_size = '0;
	logic [7:0]   frame_cmd = '0;
	logic [7:0]   xor_acc = '0;
	logic [6:0]   body_count = '0;
	logic [7:0]   body_buf [DEPTH];

	frame_beat_t run_beats [$];
	frame_beat_t frame_beats_q [$];
	frame_beat_t got_beat;
	frame_beat_t want_beat;

	int errors = 0;
	int beats_checked = 0;
	int frames_seen = 0;
	int largest_seen = 0;
	int bytes_fed = 0;
	int frame_bytes = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	int stall_tick = 0;
	res_stall_mode_t stall_mode = RS_OPEN;

	msp_frame_receiver_unit #(
		.PAYLOAD_DEPTH(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_stall(rx_stall),
		.rx_byte(rx_byte),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.command(command),
		.payload_size(payload_size),
		.data_byte(data_byte),
		.byte_index(byte_index),
		.empty_payload(empty_payload),
		.last(last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic log_error(input string msg);
		errors++;
		if (errors <= SHOWN_ERRORS) begin
			$display("%s", msg);
		end
	endtask

	// Advances the parser by one byte and leaves any completed frame with a good checksum in run_beats.
	task automatic deframe_byte(input logic [7:0] b);
		frame_beat_t beat;
		run_beats.delete();
		case (phase)
			PH_IDLE: phase = (b == CH_DOLLAR) ? PH_DOLLAR : PH_IDLE;
			PH_DOLLAR: phase = (b == CH_M) ? PH_M : PH_IDLE;
			PH_M: phase = (b == CH_GT) ? PH_ARROW : PH_IDLE;
			PH_ARROW: begin
				if (b > DEPTH) begin
					phase = PH_IDLE;
				end else begin
					want_size = b[6:0];
					xor_acc = b;
					phase = PH_SIZE;
				end
			end
			PH_SIZE: begin
				frame_cmd = b;
				xor_acc = xor_acc ^ b;
				body_count = '0;
				phase = PH_BODY;
			end
			PH_BODY: begin
				xor_acc = xor_acc ^ b;
				if (body_count >= want_size) begin
					if (xor_acc == 8'h00) begin
						if (want_size == 7'd0) begin
							beat = '{frame_cmd, 7'd0, 8'h00, 6'd0, 1'b1, 1'b1};
							run_beats.push_back(beat);
						end else begin
							for (int k = 0; k < want_size; k++) begin
								beat = '{frame_cmd, want_size, body_buf[k], 6'(k), 1'b0,
									1'(k + 1 == want_size)};
								run_beats.push_back(beat);
							end
						end
					end
					phase = PH_IDLE;
				end else begin
					body_buf[body_count[5:0]] = b;
					body_count = body_count + 7'd1;
				end
			end
			default: phase = PH_IDLE;
		endcase
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_valid && !rx_stall) begin
				bytes_fed++;
				deframe_byte(rx_byte);
				if (row_typed) begin
					if (row_has_res) begin
						frame_beats_q.push_back('{row_cmd, 7'd0, 8'h00, 6'd0, 1'b1, 1'b1});
					end
				end else begin
					foreach (run_beats[i]) begin
						frame_beats_q.push_back(run_beats[i]);
					end
				end
			end
			if (res_valid && !res_stall) begin
				got_beat = '{command, payload_size, data_byte, byte_index,
					empty_payload, last};
				beats_checked++;
				if (last === 1'b1) begin
					frames_seen++;
				end
				if (payload_size > largest_seen) begin
					largest_seen = payload_size;
				end
				if (frame_beats_q.size() == 0) begin
					log_error($sformatf({"Unexpected result beat: cmd=%h size=%0d ",
						"data=%h idx=%0d empty=%b last=%b"},
						got_beat.cmd, got_beat.size, got_beat.data, got_beat.idx,
						got_beat.empty, got_beat.last));
				end else begin
					want_beat = frame_beats_q.pop_front();
					if (got_beat.cmd !== want_beat.cmd || got_beat.size !== want_beat.size ||
							got_beat.data !== want_beat.data ||
							got_beat.idx !== want_beat.idx ||
							got_beat.empty !== want_beat.empty ||
							got_beat.last !== want_beat.last) begin
						log_error($sformatf({"Result mismatch: expected cmd=%h size=%0d ",
							"data=%h idx=%0d empty=%b last=%b, got cmd=%h size=%0d ",
							"data=%h idx=%0d empty=%b last=%b"},
							want_beat.cmd, want_beat.size, want_beat.data, want_beat.idx,
							want_beat.empty, want_beat.last, got_beat.cmd, got_beat.size,
							got_beat.data, got_beat.idx, got_beat.empty, got_beat.last));
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		if (stall_tick % 64 == 0) begin
			stall_mode <= res_stall_mode_t'($urandom_range(0, 3));
		end
		case (stall_mode)
			RS_OPEN: res_stall <= 1'b0;
			RS_RANDOM: res_stall <= ($urandom_range(0, 2) == 0);
			RS_HEAVY: res_stall <= (stall_tick % 4 != 0);
			default: res_stall <= ((stall_tick / 4) % 2 == 1);
		endcase
	end

	always @(posedge clk) begin
		if ((rx_valid && !rx_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no beat moved for %0d cycles.", IDLE_LIMIT);
			$display("msp_frame_receiver_unit verification failed");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic typed, input logic has_res,
			input logic [7:0] cmd);
		int gap;
		logic go;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				rx_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		rx_valid <= 1'b1;
		rx_byte <= b;
		row_typed <= typed;
		row_has_res <= has_res;
		row_cmd <= cmd;
		do begin
			@(negedge clk);
			go = !rx_stall;
			@(posedge clk);
		end while (!go);
	endtask

	task automatic drain_results();
		rx_valid <= 1'b0;
		do @(posedge clk); while (frame_beats_q.size() != 0);
	endtask

	task automatic send_frame(input frame_kind_t kind, input int size);
		logic [7:0] cmd;
		logic [7:0] sum;
		logic [7:0] wrong;
		logic [7:0] body [$];
		int n_ok;
		int cut;
		cmd = 8'($urandom_range(0, 255));
		case (kind)
			FK_NOISE: begin
				n_ok = $urandom_range(1, 4);
				for (int i = 0; i < n_ok; i++) begin
					send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, 8'h00);
				end
				frame_bytes += n_ok;
			end
			FK_BROKEN: begin
				n_ok = $urandom_range(1, 2);
				for (int i = 0; i < n_ok; i++) begin
					send_byte(HDR[i], 1'b0, 1'b0, 8'h00);
				end
				wrong = 8'($urandom_range(0, 255));
				if (wrong == HDR[n_ok]) begin
					wrong = wrong ^ 8'h01;
				end
				send_byte(wrong, 1'b0, 1'b0, 8'h00);
				frame_bytes += n_ok + 1;
			end
			FK_OVERSIZE: begin
				foreach (HDR[i]) send_byte(HDR[i], 1'b0, 1'b0, 8'h00);
				send_byte(8'($urandom_range(DEPTH + 1, 255)), 1'b0, 1'b0, 8'h00);
				frame_bytes += 4;
			end
			default: begin
				foreach (HDR[i]) send_byte(HDR[i], 1'b0, 1'b0, 8'h00);
				send_byte(8'(size), 1'b0, 1'b0, 8'h00);
				send_byte(cmd, 1'b0, 1'b0, 8'h00);
				sum = 8'(size) ^ cmd;
				for (int i = 0; i < size; i++) begin
					body.push_back(8'($urandom_range(0, 255)));
					sum = sum ^ body[i];
				end
				cut = (kind == FK_TRUNCATED) ? $urandom_range(0, size) : size;
				for (int i = 0; i < cut; i++) begin
					send_byte(body[i], 1'b0, 1'b0, 8'h00);
				end
				frame_bytes += 5 + cut;
				if (kind == FK_GOOD) begin
					send_byte(sum, 1'b0, 1'b0, 8'h00);
					frame_bytes++;
				end else if (kind == FK_BAD_SUM) begin
					send_byte(sum ^ 8'($urandom_range(1, 255)), 1'b0, 1'b0, 8'h00);
					frame_bytes++;
				end
			end
		endcase
	endtask

	initial begin
		int frames;
		int pick;
		int size;
		frame_kind_t kind;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_ROWS[i]) begin
			send_byte(DIR_ROWS[i].b, DIR_ROWS[i].typed, DIR_ROWS[i].has_res, DIR_ROWS[i].cmd);
		end
		drain_results();

		frames = 0;
		while (frame_bytes < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				kind = FK_GOOD;
			end else if (pick < 80) begin
				kind = FK_BAD_SUM;
			end else if (pick < 88) begin
				kind = FK_BROKEN;
			end else if (pick < 93) begin
				kind = FK_OVERSIZE;
			end else if (pick < 97) begin
				kind = FK_TRUNCATED;
			end else begin
				kind = FK_NOISE;
			end
			pick = $urandom_range(0, 99);
			if (frames == 3) begin
				kind = FK_GOOD;
				size = DEPTH;
			end else if (pick < 3) begin
				size = $urandom_range(DEPTH - 1, DEPTH);
			end else if (pick < 80) begin
				size = $urandom_range(0, 8);
			end else begin
				size = $urandom_range(9, 32);
			end
			send_frame(kind, size);
			frames++;
			if (frames % 12 == 0) begin
				drain_results();
			end
		end

		drain_results();
		repeat (TRAIL_CYCLES) @(posedge clk);
		$display("Fed %0d bytes over %0d random frame attempts after %0d directed rows.",
			bytes_fed, frames, $size(DIR_ROWS));
		$display("Checked %0d result beats from %0d accepted frames, largest payload %0d bytes.",
			beats_checked, frames_seen, largest_seen);
		if (errors == 0 && frame_beats_q.size() == 0) begin
			$display("msp_frame_receiver_unit verification clean");
		end else begin
			$display("%0d mismatches in total.", errors);
			$display("msp_frame_receiver_unit verification failed");
		end
		$finish;
	end

endmodule
